[rtl/core/lbiw_pkg.sv]
// ----------------------------------------------------------------------------
// lbiw_pkg - shared types and constants for level bracket interpolation weights
// Transaction structs, the internal command format, the back-end state
// encoding and the fixed field widths.
// ----------------------------------------------------------------------------
package lbiw_pkg;

   // default table depth and weight precision
   localparam int unsigned MAX_LEVELS       = 64;
   localparam int unsigned WEIGHT_FRAC_BITS = 16;

   // fixed field widths
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned DIFF_W  = VALUE_W + 1;

   // full weight, 1.0 in Q1.WEIGHT_FRAC_BITS
   localparam logic [WEIGHT_FRAC_BITS:0] ONE_WEIGHT =
      (WEIGHT_FRAC_BITS+1)'(1) << WEIGHT_FRAC_BITS;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // point counts
   localparam logic [1:0] POINTS_ONE = 2'd1;
   localparam logic [1:0] POINTS_TWO = 2'd2;

   // input transaction
   typedef struct packed {
      logic                      operation;
      logic [IDX_W-1:0]          level_index;
      logic signed [VALUE_W-1:0] level_value;
      logic signed [VALUE_W-1:0] target_level;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [1:0]                  point_count;
      logic [IDX_W-1:0]            lower_index;
      logic [IDX_W-1:0]            upper_index;
      logic [WEIGHT_FRAC_BITS:0]   lower_weight;
      logic [WEIGHT_FRAC_BITS-1:0] upper_weight;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic                      is_query;
      logic [IDX_W-1:0]          index;
      logic signed [VALUE_W-1:0] value;   // level for writes, target for queries
   } cmd_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV
   } back_state_type;

endpackage

[rtl/core/lbiw_ram.sv]
// ----------------------------------------------------------------------------
// lbiw_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lbiw_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lbiw_front.sv]
// ----------------------------------------------------------------------------
// lbiw_front - transaction intake and classification
// Accepts input transactions, drops table writes that fall outside the
// table, and queues the rest as commands in a two-entry queue.
// ----------------------------------------------------------------------------
module lbiw_front #(
   parameter int unsigned MAX_LEVELS = lbiw_pkg::MAX_LEVELS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lbiw_pkg::req_type req_data,
   output logic              cmd_valid,
   output lbiw_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   localparam int unsigned QUEUE_DEPTH = 2;

   lbiw_pkg::cmd_type queue_ff [QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              accept;
   logic              keep;
   logic              push;
   logic              pop;
   lbiw_pkg::cmd_type new_cmd;

   assign busy   = (count_ff == 2'(QUEUE_DEPTH));
   assign accept = start && !busy;

   // classify: a query always, a write only when it lands inside the table
   always_comb begin
      new_cmd.is_query = (req_data.operation == lbiw_pkg::OP_QUERY);
      new_cmd.index    = req_data.level_index;
      new_cmd.value    = new_cmd.is_query ? req_data.target_level : req_data.level_value;
      keep             = new_cmd.is_query || (32'(req_data.level_index) < MAX_LEVELS);
   end

   assign push = accept && keep;
   assign pop  = cmd_pop && (count_ff != 2'd0);

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

endmodule

[rtl/core/lbiw_div.sv]
// ----------------------------------------------------------------------------
// lbiw_div - restoring divider for the fractional weight
// Computes floor(num * 2^WEIGHT_FRAC_BITS / den) for num < den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbiw_div (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [lbiw_pkg::DIFF_W-1:0]              num,
   input  logic [lbiw_pkg::DIFF_W-1:0]              den,
   output logic                                     done,
   output logic [lbiw_pkg::WEIGHT_FRAC_BITS-1:0]    quot
);

   localparam int unsigned QW     = lbiw_pkg::WEIGHT_FRAC_BITS;
   localparam int unsigned DW     = lbiw_pkg::DIFF_W;
   localparam int unsigned STEP_W = $clog2(QW + 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic [DW:0]       shifted;
   logic [DW:0]       diff;

   // one restoring step: shift, trial subtract, keep on no borrow
   always_comb begin
      shifted   = {rem_ff, 1'b0};
      diff      = shifted - {1'b0, den_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = STEP_W'(QW);
         rem_in    = num;
         den_in    = den;
      end else if (active_ff) begin
         if (!diff[DW]) begin
            rem_in  = diff[DW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[rtl/core/lbiw_back.sv]
// ----------------------------------------------------------------------------
// lbiw_back - command execution
// Applies table writes, scans the table for a query's bracket one level per
// cycle, runs the weight division and registers the result strobe.
// ----------------------------------------------------------------------------
module lbiw_back #(
   parameter int unsigned MAX_LEVELS = lbiw_pkg::MAX_LEVELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  lbiw_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   input  logic                          csr_write_enable,
   input  logic [lbiw_pkg::COUNT_W-1:0]  csr_write_data,
   output logic                          rsp_valid,
   output lbiw_pkg::rsp_type             rsp_data
);

   localparam int unsigned IW = $clog2(MAX_LEVELS);
   localparam int unsigned CW = $clog2(MAX_LEVELS + 1);
   localparam int unsigned VW = lbiw_pkg::VALUE_W;
   localparam int unsigned DW = lbiw_pkg::DIFF_W;
   localparam int unsigned QW = lbiw_pkg::WEIGHT_FRAC_BITS;

   lbiw_pkg::back_state_type state_ff, state_in;

   logic [lbiw_pkg::COUNT_W-1:0] level_count_ff;
   logic [CW-1:0]                n_used;
   logic [CW-1:0]                n_ff, n_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic signed [VW-1:0]         target_ff, target_in;
   logic signed [VW-1:0]         prev_ff, prev_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lbiw_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         ram_we;
   logic [VW-1:0]                ram_rd_data;
   logic signed [VW-1:0]         level;
   logic                         scan_hit;
   logic                         scan_last;
   logic                         div_start;
   logic                         div_done;
   logic [DW-1:0]                div_num;
   logic [DW-1:0]                div_den;
   logic [QW-1:0]                div_quot;

   // level count register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= lbiw_pkg::COUNT_W'(1);
      end else if (csr_write_enable) begin
         level_count_ff <= csr_write_data;
      end
   end

   // used levels: zero counts as one, large counts clamp to the table depth
   always_comb begin
      if (level_count_ff == '0) begin
         n_used = CW'(1);
      end else if (32'(level_count_ff) > MAX_LEVELS) begin
         n_used = CW'(MAX_LEVELS);
      end else begin
         n_used = CW'(level_count_ff);
      end
   end

   // level table
   lbiw_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_LEVELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IW'(cmd.index)),
      .wr_data (cmd.value),
      .rd_addr (idx_in[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   // scan compare on the level read for idx_ff
   assign level     = $signed(ram_rd_data);
   assign scan_hit  = (target_ff < level);
   assign scan_last = (CW'(idx_ff + CW'(1)) == n_ff);
   assign div_num   = {target_ff[VW-1], target_ff} - {prev_ff[VW-1], prev_ff};
   assign div_den   = {level[VW-1], level} - {prev_ff[VW-1], prev_ff};

   lbiw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbiw_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.is_query) begin
               state_in = lbiw_pkg::ST_SCAN;
            end
         end
         lbiw_pkg::ST_SCAN: begin
            if (scan_hit) begin
               state_in = (idx_ff == '0) ? lbiw_pkg::ST_IDLE : lbiw_pkg::ST_DIV;
            end else if (scan_last) begin
               state_in = lbiw_pkg::ST_IDLE;
            end
         end
         lbiw_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = lbiw_pkg::ST_IDLE;
            end
         end
         default: state_in = lbiw_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      idx_in       = idx_ff;
      n_in         = n_ff;
      target_in    = target_ff;
      prev_in      = prev_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         lbiw_pkg::ST_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               if (cmd.is_query) begin
                  idx_in    = '0;
                  n_in      = n_used;
                  target_in = cmd.value;
               end else begin
                  ram_we = 1'b1;
               end
            end
         end
         lbiw_pkg::ST_SCAN: begin
            if (scan_hit && (idx_ff == '0)) begin
               // below the first level
               rsp_valid_in        = 1'b1;
               rsp_in.point_count  = lbiw_pkg::POINTS_ONE;
               rsp_in.lower_index  = '0;
               rsp_in.upper_index  = '0;
               rsp_in.lower_weight = lbiw_pkg::ONE_WEIGHT;
               rsp_in.upper_weight = '0;
            end else if (scan_hit) begin
               div_start = 1'b1;
            end else if (scan_last) begin
               // at or above the last used level
               rsp_valid_in        = 1'b1;
               rsp_in.point_count  = lbiw_pkg::POINTS_ONE;
               rsp_in.lower_index  = lbiw_pkg::IDX_W'(idx_ff);
               rsp_in.upper_index  = '0;
               rsp_in.lower_weight = lbiw_pkg::ONE_WEIGHT;
               rsp_in.upper_weight = '0;
            end else begin
               prev_in = level;
               idx_in  = CW'(idx_ff + CW'(1));
            end
         end
         lbiw_pkg::ST_DIV: begin
            if (div_done) begin
               rsp_valid_in        = 1'b1;
               rsp_in.point_count  = lbiw_pkg::POINTS_TWO;
               rsp_in.lower_index  = lbiw_pkg::IDX_W'(CW'(idx_ff - CW'(1)));
               rsp_in.upper_index  = lbiw_pkg::IDX_W'(idx_ff);
               rsp_in.lower_weight = lbiw_pkg::ONE_WEIGHT - {1'b0, div_quot};
               rsp_in.upper_weight = div_quot;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbiw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      target_ff <= target_in;
      prev_ff   <= prev_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/level_bracket_interp_weights.sv]
// A query's result strobe follows its scan of the used levels when clamped, and the weight
// division as well when bracketing. The back end works on one command at a time; a two-entry
// command queue takes new transactions meanwhile. The receiver cannot stall results.
// Synchronous reset clears control state and sets level_count to 1; the table stays undefined.
// ----------------------------------------------------------------------------
// level_bracket_interp_weights - piecewise linear interpolation weights
// Holds a table of ascending levels and returns the bracketing indices and
// Q1.16 lower and Q0.16 upper weights for a target level.
// ----------------------------------------------------------------------------
module level_bracket_interp_weights #(
   parameter int unsigned MAX_LEVELS = lbiw_pkg::MAX_LEVELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lbiw_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output lbiw_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [lbiw_pkg::COUNT_W-1:0]  csr_write_data
);

   logic              cmd_valid;
   logic              cmd_pop;
   lbiw_pkg::cmd_type cmd;

   // intake and queue
   lbiw_front #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // execution
   lbiw_back #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

endmodule
